### rtl/cgpb_pkg.sv
package cgpb_pkg;

    // request actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_OVER  = 2'd2;
    localparam logic [1:0] ACT_UNDER = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_POLL_TICKS    = 2'd0;
    localparam logic [1:0] REG_ABORT_LIMIT   = 2'd1;
    localparam logic [1:0] REG_CELL_COUNT    = 2'd2;
    localparam logic [1:0] REG_FIRST_CELL_ID = 2'd3;

    localparam logic [7:0] RST_POLL_TICKS    = 8'd38;
    localparam logic [7:0] RST_ABORT_LIMIT   = 8'd10;
    localparam logic [5:0] RST_CELL_COUNT    = 6'd18;
    localparam logic [7:0] RST_FIRST_CELL_ID = 8'd7;

    // result kinds
    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // query header bytes
    localparam logic [7:0] QRY_HEAD0 = 8'h81;
    localparam logic [7:0] QRY_HEAD1 = 8'hAA;
    localparam logic [2:0] QRY_LEN   = 3'd4;

    // width of group count arithmetic (covers a group count of up to 256)
    localparam int GRP_CNT_W = 9;

    // voltage scaling: floor(raw * 255 / 1000), saturated at 255
    localparam logic [15:0] SAT_RAW   = 16'd1004;
    localparam logic [18:0] RECIP_1K  = 19'd268436;  // ceil(2^28 / 1000)
    localparam int          RECIP_SHR = 28;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_READ,
        FR_TAIL,
        FR_SEND
    } fr_state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [7:0] cell_id;
        logic [7:0] volt_a;
        logic [7:0] volt_b;
        logic [7:0] volt_c;
        logic [7:0] volt_d;
        logic       over_fault;
        logic       under_fault;
        logic       comms_fault;
        logic       last;
    } rsp_t;

endpackage

### rtl/cell_group_poll_bridge_core.sv
// Polling bridge between a cell monitor and a status bus.
//
// Request channel (req_valid / req_stall / req_data): one event per request,
// a timer tick, a received serial byte, or an over/undervoltage fault.
// Result channel (rsp_valid / rsp_stall / rsp_data): query bytes to transmit
// (kind 0) and status frames (kind 1); last marks the final result of a
// request. Configuration: cfg_we / cfg_index / cfg_wdata, written while idle.
//
// Received bytes go into a reply store (one synchronous RAM, registered read).
// A tick that starts a poll produces four query bytes through the burst counter
// and the output register; they leave at one per cycle unless the receiver stalls,
// and the next request is taken once the fourth is in the output register.
// The final reply byte starts a frame: eight reads of the store through the
// single read port, one shared scaling unit for the voltage pairs, then the frame
// is offered. Other requests produce no result and do not hold the channel.
// A stalled receiver holds the output register; the generator waits on it.
// Reset: configuration to its defaults, a poll pending, counters and flags
// cleared. The reply store is not cleared; it is always filled first.
module cell_group_poll_bridge_core #(
    parameter int REPLY_LENGTH = 29,
    parameter int MAX_GROUPS   = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cgpb_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cgpb_pkg::rsp_t  rsp_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_wdata
);

    import cgpb_pkg::*;

    localparam int AW = $clog2(REPLY_LENGTH);
    localparam int BW = $clog2(REPLY_LENGTH + 1);
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    // configuration
    logic [7:0] poll_ticks_reg;
    logic [7:0] abort_limit_reg;
    logic [5:0] cell_count_reg;
    logic [7:0] first_id_reg;

    // poll and reply control
    logic [7:0]    tick_count_reg, tick_count_next;
    logic          poll_pending_reg, poll_pending_next;
    logic [7:0]    abort_count_reg, abort_count_next;
    logic [GW-1:0] group_idx_reg, group_idx_next;
    logic [BW-1:0] byte_idx_reg, byte_idx_next;
    logic          over_reg, over_next;
    logic          under_reg, under_next;
    logic          comms_reg, comms_next;

    // query burst generator
    logic [2:0] q_cnt_reg, q_cnt_next;
    logic [7:0] q_id_reg, q_id_next;

    // frame sequencer
    fr_state_t  st_reg, st_next;
    logic [2:0] rd_cnt_reg, rd_cnt_next;
    logic       rd_vld_reg, rd_vld_next;
    logic [2:0] rd_sel_reg;
    logic [7:0] lo_reg;
    logic [7:0] volt_reg [4];
    logic [7:0] frame_id_reg;
    logic       f_over_reg, f_under_reg, f_comms_reg;

    // output register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic          req_fire;
    logic          frame_start;
    logic          out_free;
    logic          load_query;
    logic          load_frame;
    logic [7:0]    cur_id;
    logic [3:0]    rd_pos;
    logic [7:0]    ram_rdata;
    logic          ram_we;
    logic [8:0]    tick_inc;
    logic [8:0]    abort_inc;
    logic [GRP_CNT_W-1:0] grp_cnt;
    logic [GRP_CNT_W-1:0] grp_inc;
    logic [GW-1:0] grp_adv;
    logic [BW-1:0] byte_inc;
    logic [15:0]   raw;
    logic [17:0]   raw_x255;
    logic [36:0]   quot_prod;
    logic [7:0]    volt_val;
    rsp_t          rsp_new;

    // hold new requests while a burst or a frame is being produced
    assign req_stall = (q_cnt_reg != 3'd0) || (st_reg != FR_IDLE);
    assign req_fire  = req_valid && !req_stall;

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign load_query = out_free && (q_cnt_reg != 3'd0);
    assign load_frame = out_free && (st_reg == FR_SEND);

    assign cur_id = first_id_reg + 8'(group_idx_reg);

    // voltage pairs sit at 4*j+2 (low) and 4*j+3 (high)
    assign rd_pos = {rd_cnt_reg[2:1], 1'b1, rd_cnt_reg[0]};

    assign ram_we = req_fire && (req_data.action == ACT_BYTE);

    cgpb_ram #(
        .WIDTH (8),
        .DEPTH (REPLY_LENGTH)
    ) u_reply_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(byte_idx_reg)),
        .wdata (req_data.rx_byte),
        .raddr (AW'(rd_pos)),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_ticks_reg  <= RST_POLL_TICKS;
            abort_limit_reg <= RST_ABORT_LIMIT;
            cell_count_reg  <= RST_CELL_COUNT;
            first_id_reg    <= RST_FIRST_CELL_ID;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLL_TICKS:    poll_ticks_reg  <= cfg_wdata;
                REG_ABORT_LIMIT:   abort_limit_reg <= cfg_wdata;
                REG_CELL_COUNT:    cell_count_reg  <= cfg_wdata[5:0];
                REG_FIRST_CELL_ID: first_id_reg    <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // request decode: tick counting, polls, aborts, reply filling
    always_comb
    begin
        tick_count_next   = tick_count_reg;
        poll_pending_next = poll_pending_reg;
        abort_count_next  = abort_count_reg;
        group_idx_next    = group_idx_reg;
        byte_idx_next     = byte_idx_reg;
        over_next         = over_reg;
        under_next        = under_reg;
        comms_next        = comms_reg;
        q_id_next         = q_id_reg;
        frame_start       = 1'b0;

        tick_inc  = {1'b0, tick_count_reg} + 9'd1;
        abort_inc = {1'b0, abort_count_reg} + 9'd1;
        byte_inc  = byte_idx_reg + BW'(1);

        // clamp the group count into 1..MAX_GROUPS
        grp_cnt = GRP_CNT_W'(cell_count_reg);
        if (grp_cnt == '0)
        begin
            grp_cnt = GRP_CNT_W'(1);
        end
        if (grp_cnt > GRP_CNT_W'(MAX_GROUPS))
        begin
            grp_cnt = GRP_CNT_W'(MAX_GROUPS);
        end
        grp_inc = GRP_CNT_W'(group_idx_reg) + GRP_CNT_W'(1);
        grp_adv = (grp_inc >= grp_cnt) ? '0 : GW'(grp_inc);

        if (req_fire)
        begin
            case (req_data.action)
                ACT_OVER:
                begin
                    over_next = 1'b1;
                end
                ACT_UNDER:
                begin
                    under_next = 1'b1;
                end
                ACT_BYTE:
                begin
                    if (byte_inc >= BW'(REPLY_LENGTH))
                    begin
                        // reply complete: start a frame, drop the comms flag
                        byte_idx_next = '0;
                        comms_next    = 1'b0;
                        frame_start   = 1'b1;
                    end
                    else
                    begin
                        byte_idx_next = byte_inc;
                    end
                end
                default:
                begin
                    // timer tick
                    if (tick_inc > {1'b0, poll_ticks_reg})
                    begin
                        poll_pending_next = 1'b1;
                        tick_count_next   = '0;
                    end
                    else
                    begin
                        tick_count_next = tick_inc[7:0];
                    end
                    if (poll_pending_next)
                    begin
                        poll_pending_next = 1'b0;
                        if (byte_idx_reg != '0)
                        begin
                            // reply still arriving: abort this poll
                            if (abort_inc > {1'b0, abort_limit_reg})
                            begin
                                comms_next       = 1'b1;
                                abort_count_next = '0;
                                byte_idx_next    = '0;
                            end
                            else
                            begin
                                abort_count_next = abort_inc[7:0];
                            end
                        end
                        else
                        begin
                            abort_count_next = '0;
                            group_idx_next   = grp_adv;
                            q_id_next        = first_id_reg + 8'(grp_adv);
                        end
                    end
                end
            endcase
        end
    end

    // query burst counter
    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (load_query)
        begin
            q_cnt_next = q_cnt_reg - 3'd1;
        end
        if (req_fire && (req_data.action == ACT_TICK) && (poll_pending_reg ||
            (tick_inc > {1'b0, poll_ticks_reg})) && (byte_idx_reg == '0))
        begin
            q_cnt_next = QRY_LEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            poll_pending_reg <= 1'b1;
            abort_count_reg  <= '0;
            group_idx_reg    <= '0;
            byte_idx_reg     <= '0;
            over_reg         <= 1'b0;
            under_reg        <= 1'b0;
            comms_reg        <= 1'b0;
            q_cnt_reg        <= '0;
        end
        else
        begin
            tick_count_reg   <= tick_count_next;
            poll_pending_reg <= poll_pending_next;
            abort_count_reg  <= abort_count_next;
            group_idx_reg    <= group_idx_next;
            byte_idx_reg     <= byte_idx_next;
            over_reg         <= over_next;
            under_reg        <= under_next;
            comms_reg        <= comms_next;
            q_cnt_reg        <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_id_reg <= q_id_next;
        if (frame_start)
        begin
            // snapshot what the frame reports
            frame_id_reg <= cur_id;
            f_over_reg   <= over_reg;
            f_under_reg  <= under_reg;
            f_comms_reg  <= comms_reg;
        end
    end

    // frame sequencer: read the four voltage pairs from the reply store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= FR_IDLE;
            rd_cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            rd_cnt_reg <= rd_cnt_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_comb
    begin
        st_next     = st_reg;
        rd_cnt_next = rd_cnt_reg;
        rd_vld_next = 1'b0;
        case (st_reg)
            FR_IDLE:
            begin
                if (frame_start)
                begin
                    st_next     = FR_READ;
                    rd_cnt_next = '0;
                end
            end
            FR_READ:
            begin
                rd_vld_next = 1'b1;
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == 3'd7)
                begin
                    st_next = FR_TAIL;
                end
            end
            FR_TAIL:
            begin
                // last high byte is being scaled
                st_next = FR_SEND;
            end
            FR_SEND:
            begin
                if (load_frame)
                begin
                    st_next = FR_IDLE;
                end
            end
            default:
            begin
                st_next = FR_IDLE;
            end
        endcase
    end

    // shared scaling unit: floor(raw * 255 / 1000), saturated at 255
    always_comb
    begin
        raw       = {ram_rdata, lo_reg};
        raw_x255  = {raw[9:0], 8'd0} - {8'd0, raw[9:0]};
        quot_prod = 37'(raw_x255) * 37'(RECIP_1K);
        if (raw >= SAT_RAW)
        begin
            volt_val = 8'hFF;
        end
        else
        begin
            volt_val = quot_prod[RECIP_SHR+7:RECIP_SHR];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_sel_reg <= rd_cnt_reg;
        if (rd_vld_reg)
        begin
            if (!rd_sel_reg[0])
            begin
                lo_reg <= ram_rdata;
            end
            else
            begin
                volt_reg[rd_sel_reg[2:1]] <= volt_val;
            end
        end
    end

    // result mux into the output register
    always_comb
    begin
        rsp_new = '0;
        if (st_reg == FR_SEND)
        begin
            rsp_new.kind        = KIND_FRAME;
            rsp_new.cell_id     = frame_id_reg;
            rsp_new.volt_a      = volt_reg[0];
            rsp_new.volt_b      = volt_reg[1];
            rsp_new.volt_c      = volt_reg[2];
            rsp_new.volt_d      = volt_reg[3];
            rsp_new.over_fault  = f_over_reg;
            rsp_new.under_fault = f_under_reg;
            rsp_new.comms_fault = f_comms_reg;
            rsp_new.last        = 1'b1;
        end
        else
        begin
            rsp_new.kind = KIND_QUERY;
            case (q_cnt_reg)
                3'd4:    rsp_new.tx_byte = QRY_HEAD0;
                3'd3:    rsp_new.tx_byte = QRY_HEAD1;
                default: rsp_new.tx_byte = q_id_reg;
            endcase
            rsp_new.last = (q_cnt_reg == 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= load_query || load_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_query || load_frame)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // a query burst and a frame are never in flight together
    a_burst_frame_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !((q_cnt_reg != 3'd0) && (st_reg != FR_IDLE)))
        else $error("query burst overlaps frame sequence");

    // the reply write pointer never reaches the store depth
    a_byte_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_idx_reg < BW'(REPLY_LENGTH))
        else $error("reply byte index out of range");

    // a loaded frame closes its request
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        load_frame |=> (rsp_valid && rsp_data.kind == KIND_FRAME && rsp_data.last))
        else $error("frame not presented as final result");

    // a burst opens with the first header byte
    a_burst_head: assert property (@(posedge clk) disable iff (!rst_n)
        (load_query && q_cnt_reg == QRY_LEN) |=> (rsp_data.tx_byte == QRY_HEAD0))
        else $error("query burst does not open with header");

endmodule

### rtl/cgpb_ram.sv
module cgpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 29
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/tb_cell_group_poll_bridge_core.sv
module tb_cell_group_poll_bridge_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cgpb_pkg::*;

    localparam int REPLY_LEN     = 29;
    localparam int MAX_GRP       = 32;
    // margin after the last result for requests still inside the bridge
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 3000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_t       req_data  = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_t       rsp_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = REG_POLL_TICKS;
    logic [7:0] cfg_wdata = '0;

    cell_group_poll_bridge_core #(
        .REPLY_LENGTH (REPLY_LEN),
        .MAX_GROUPS   (MAX_GRP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow of the bridge: register copies and poll/reply state
    // ------------------------------------------------------------------
    logic [7:0] set_poll_ticks  = RST_POLL_TICKS;
    logic [7:0] set_abort_limit = RST_ABORT_LIMIT;
    logic [5:0] set_cell_count  = RST_CELL_COUNT;
    logic [7:0] set_first_id    = RST_FIRST_CELL_ID;

    int         tick_cnt   = 0;
    bit         poll_due   = 1'b1;   // reset leaves a poll pending
    int         abort_cnt  = 0;
    int         grp        = 0;
    int         byte_pos   = 0;
    logic [7:0] reply_mem [REPLY_LEN];
    bit         over_seen  = 1'b0;
    bit         under_seen = 1'b0;
    bit         comms_seen = 1'b0;

    // requests waiting to be offered, and results the bridge still owes us
    req_t       queued_events [$];
    rsp_t       awaited_results [$];
    rsp_t       oldest_result;

    int         events_queued = 0;
    int         events_taken  = 0;
    int         mismatches    = 0;

    // knobs for the two sides, set by the sequence below
    bit         send_gaps     = 1'b1;
    bit         take_gaps     = 1'b1;
    int         hold_requests = 0;
    int         holds_served  = 0;
    int         send_hold     = 0;
    int         take_hold     = 0;
    int         quiet_cycles  = 0;

    function automatic logic [7:0] group_id();
        // identifiers wrap modulo 256
        return set_first_id + 8'(grp);
    endfunction

    function automatic logic [7:0] scaled_volt(int lo);
        int unsigned raw;
        int unsigned s;
        raw = {reply_mem[lo + 1], reply_mem[lo]};
        s   = raw * 255 / 1000;
        return (s > 255) ? 8'hFF : 8'(s);
    endfunction

    function automatic void push_query(logic [7:0] tx, logic fin);
        rsp_t q;
        q         = '0;
        q.kind    = KIND_QUERY;
        q.tx_byte = tx;
        q.last    = fin;
        awaited_results.push_back(q);
    endfunction

    // Advance the shadow by one accepted request and queue what it causes.
    function automatic void bridge_step(req_t r);
        rsp_t f;
        int   groups;
        case (r.action)
            ACT_OVER:  over_seen  = 1'b1;
            ACT_UNDER: under_seen = 1'b1;
            ACT_BYTE:
            begin
                // bytes are stored whether or not a query is outstanding
                reply_mem[byte_pos] = r.rx_byte;
                byte_pos++;
                if (byte_pos >= REPLY_LEN)
                begin
                    f             = '0;
                    f.kind        = KIND_FRAME;
                    f.cell_id     = group_id();
                    f.volt_a      = scaled_volt(2);
                    f.volt_b      = scaled_volt(6);
                    f.volt_c      = scaled_volt(10);
                    f.volt_d      = scaled_volt(14);
                    f.over_fault  = over_seen;
                    f.under_fault = under_seen;
                    f.comms_fault = comms_seen;
                    f.last        = 1'b1;
                    awaited_results.push_back(f);
                    byte_pos   = 0;
                    comms_seen = 1'b0;   // shown once, then drop it
                end
            end
            default:
            begin
                // compare without wrap, so a limit of 255 fires on tick 256
                if (tick_cnt + 1 > int'(set_poll_ticks))
                begin
                    poll_due = 1'b1;
                    tick_cnt = 0;
                end
                else
                    tick_cnt = tick_cnt + 1;

                if (poll_due)
                begin
                    poll_due = 1'b0;
                    if (byte_pos > 0)
                    begin
                        // a reply is half in: abort, and past the limit drop it
                        if (abort_cnt + 1 > int'(set_abort_limit))
                        begin
                            comms_seen = 1'b1;
                            abort_cnt  = 0;
                            byte_pos   = 0;
                        end
                        else
                            abort_cnt = abort_cnt + 1;
                    end
                    else
                    begin
                        abort_cnt = 0;
                        // zero groups behaves as one, too many as the maximum
                        groups = (set_cell_count == 0) ? 1 :
                                 (set_cell_count > MAX_GRP) ? MAX_GRP : int'(set_cell_count);
                        grp++;
                        if (grp >= groups)
                            grp = 0;
                        push_query(QRY_HEAD0, 1'b0);
                        push_query(QRY_HEAD1, 1'b0);
                        push_query(group_id(), 1'b0);
                        push_query(group_id(), 1'b1);
                    end
                end
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_event(logic [1:0] act, logic [7:0] rx);
        req_t ev;
        ev.action  = act;
        ev.rx_byte = rx;
        queued_events.push_back(ev);
        events_queued++;
    endtask

    task automatic queue_ticks(int n);
        for (int i = 0; i < n; i++)
            push_event(ACT_TICK, 8'($urandom));
    endtask

    // Reply bytes with random content; keep the voltage high bytes small half
    // the time so that unsaturated readings turn up as often as saturated ones.
    task automatic queue_reply(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            if ((i inside {3, 7, 11, 15}) && $urandom_range(0, 1))
                b = 8'($urandom_range(0, 4));
            push_event(ACT_BYTE, b);
        end
    endtask

    // Mostly well-formed polls and replies, with broken replies and noise.
    task automatic queue_mix(int n);
        int added;
        int pick;
        int k;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                k = $urandom_range(1, 8);
                queue_ticks(k);
            end
            else if (pick < 65)
            begin
                k = REPLY_LEN;
                queue_reply(k);
            end
            else if (pick < 75)
            begin
                k = $urandom_range(1, REPLY_LEN - 1);
                queue_reply(k);
            end
            else if (pick < 87)
            begin
                k = 1;
                push_event($urandom_range(0, 1) ? ACT_OVER : ACT_UNDER, 8'($urandom));
            end
            else
            begin
                k = 1;
                push_event(2'($urandom), 8'($urandom));
            end
            added += k;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLL_TICKS:    set_poll_ticks  = val;
            REG_ABORT_LIMIT:   set_abort_limit = val;
            REG_CELL_COUNT:    set_cell_count  = val[5:0];
            REG_FIRST_CELL_ID: set_first_id    = val;
            default: ;
        endcase
    endtask

    task automatic program_phase(logic [7:0] pt, logic [7:0] al, logic [5:0] cc,
                                 logic [7:0] fid);
        write_reg(REG_POLL_TICKS, pt);
        write_reg(REG_ABORT_LIMIT, al);
        write_reg(REG_CELL_COUNT, {2'b00, cc});
        write_reg(REG_FIRST_CELL_ID, fid);
    endtask

    // Wait until every request is in and every result out, then let any
    // result-free request finish inside the bridge.
    task automatic settle();
        while (events_taken != events_queued || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver: offer queued requests, with random idle bursts.
    // A stalled request is held unchanged until it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            send_hold <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                bridge_step(req_data);
                events_taken++;
            end
            if (!req_valid || !req_stall)
            begin
                if (send_hold > 0)
                begin
                    send_hold <= send_hold - 1;
                    req_valid <= 1'b0;
                end
                else if (send_gaps && $urandom_range(0, 7) == 0)
                begin
                    // start an idle burst, its length drawn into send_hold
                    send_hold <= $urandom_range(0, 17);
                    req_valid <= 1'b0;
                end
                else if (queued_events.size() != 0)
                begin
                    req_data  <= queued_events.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken result with the oldest one owed,
    // and drive the stall side, including the one long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            take_hold <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with nothing awaited: %h", rsp_data);
                    mismatches++;
                end
                else
                begin
                    oldest_result = awaited_results.pop_front();
                    check_field("kind", 8'(oldest_result.kind), 8'(rsp_data.kind));
                    check_field("tx_byte", oldest_result.tx_byte, rsp_data.tx_byte);
                    check_field("cell_id", oldest_result.cell_id, rsp_data.cell_id);
                    check_field("volt_a", oldest_result.volt_a, rsp_data.volt_a);
                    check_field("volt_b", oldest_result.volt_b, rsp_data.volt_b);
                    check_field("volt_c", oldest_result.volt_c, rsp_data.volt_c);
                    check_field("volt_d", oldest_result.volt_d, rsp_data.volt_d);
                    check_field("over_fault", 8'(oldest_result.over_fault),
                                8'(rsp_data.over_fault));
                    check_field("under_fault", 8'(oldest_result.under_fault),
                                8'(rsp_data.under_fault));
                    check_field("comms_fault", 8'(oldest_result.comms_fault),
                                8'(rsp_data.comms_fault));
                    check_field("last", 8'(oldest_result.last), 8'(rsp_data.last));
                end
            end

            if (holds_served != hold_requests)
            begin
                // long hold-off: let the bridge back up into its request side
                holds_served++;
                take_hold <= LONG_HOLD - 1;
                rsp_stall <= 1'b1;
            end
            else if (take_hold > 0)
            begin
                take_hold <= take_hold - 1;
                rsp_stall <= 1'b1;
            end
            else if (take_gaps && $urandom_range(0, 7) == 0)
            begin
                take_hold <= $urandom_range(0, 17);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] corner_reply [REPLY_LEN];

        for (int i = 0; i < REPLY_LEN; i++)
            corner_reply[i] = (i % 2) ? 8'hA5 : 8'h5A;
        // readings: zero, just under full scale, first saturating, maximum
        corner_reply[2]  = 8'h00;
        corner_reply[3]  = 8'h00;
        corner_reply[6]  = 8'hE7;
        corner_reply[7]  = 8'h03;
        corner_reply[10] = 8'hEC;
        corner_reply[11] = 8'h03;
        corner_reply[14] = 8'hFF;
        corner_reply[15] = 8'hFF;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the first tick polls group one straight away, both
        // fault kinds latch, a second tick does nothing, then a full reply.
        push_event(ACT_TICK, 8'hFF);
        push_event(ACT_OVER, 8'h00);
        push_event(ACT_UNDER, 8'hFF);
        push_event(ACT_TICK, 8'h00);
        for (int i = 0; i < REPLY_LEN; i++)
            push_event(ACT_BYTE, corner_reply[i]);
        settle();

        // Every tick polls and the first abort drops the reply: show the comms
        // flag in the next frame, then walk all 32 groups from the top id.
        program_phase(8'd0, 8'd0, 6'd32, 8'd223);
        push_event(ACT_BYTE, 8'h3C);
        queue_ticks(2);
        queue_reply(REPLY_LEN);
        queue_ticks(34);
        queue_mix(20);
        settle();

        // One group only; hold the receiver off long enough to back up the
        // bridge while requests keep coming.
        program_phase(8'd1, 8'd2, 6'd1, 8'd0);
        queue_mix(30);
        hold_requests <= hold_requests + 1;
        settle();

        // Widest limits: the poll comes only on tick 256. Finish any
        // half-received reply first so the later one lines up.
        program_phase(8'd255, 8'd255, 6'd0, 8'd255);
        if (byte_pos != 0)
            queue_reply(REPLY_LEN - byte_pos);
        queue_ticks(257);
        queue_reply(REPLY_LEN);
        settle();

        // Over-range group count and wrapping ids, with both sides flat out.
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        program_phase(8'd3, 8'd1, 6'd63, 8'd250);
        queue_mix(15);
        settle();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### cell_group_poll_bridge_core.f
rtl/cgpb_pkg.sv
rtl/cgpb_ram.sv
rtl/cell_group_poll_bridge_core.sv
tb/tb_cell_group_poll_bridge_core.sv
